// ===== rtl/skts_pkg.sv =====
// Package for the sorted key table search block.
// Holds the record, item, command and status types shared by all files.
// No dependencies.
package skts_pkg;

    localparam int KEY_W   = 32;
    localparam int NAME_W  = 32;
    localparam int GRADE_W = 16;
    localparam int POS_W   = 4;
    localparam int ENT_W   = 5;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_SEARCH = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [KEY_W-1:0]   key;
        logic [NAME_W-1:0]         name_tag;
        logic [GRADE_W-1:0]        grade;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          position;
        logic [NAME_W-1:0]         found_name;
        logic [GRADE_W-1:0]        found_grade;
        logic [ENT_W-1:0]          entries;
    } t_out_item;

    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic [NAME_W-1:0]         name_tag;
        logic [GRADE_W-1:0]        grade;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CARRY,
        S_CMP,
        S_WLAST,
        S_BS_ISSUE,
        S_BS_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_first;
        logic take_carry;
        logic step;
        logic wlast;
        logic bs_issue;
        logic bs_cmp;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic is_search;
        logic below_two;
        logic pass_end;
        logic last_one;
        logic bs_empty;
        logic bs_hit;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/skts_in_if.sv =====
// Input channel of the sorted key table search block.
// Carries valid, ready and one input item; depends on skts_pkg.
interface skts_in_if;
    logic                valid;
    logic                ready;
    skts_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/skts_out_if.sv =====
// Output channel of the sorted key table search block.
// Carries valid, ready and one result item; depends on skts_pkg.
interface skts_out_if;
    logic                 valid;
    logic                 ready;
    skts_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/skts_ctrl.sv =====
// Controller state machine of the sorted key table search block.
// Sequences insert, bubble-sort passes and binary search; depends on skts_pkg.
module skts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  skts_pkg::t_sts  i_sts,
    output skts_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);
    import skts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_sts.is_search) begin
                        n_state = S_DONE;
                    end else if (i_sts.below_two) begin
                        n_state = S_BS_ISSUE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD:  n_state = S_CARRY;
            S_CARRY: n_state = S_CMP;
            S_CMP: begin
                if (i_sts.pass_end) begin
                    n_state = S_WLAST;
                end
            end
            S_WLAST: begin
                n_state = i_sts.last_one ? S_BS_ISSUE : S_LOAD;
            end
            S_BS_ISSUE: begin
                n_state = i_sts.bs_empty ? S_DONE : S_BS_CMP;
            end
            S_BS_CMP: begin
                n_state = i_sts.bs_hit ? S_DONE : S_BS_ISSUE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_LOAD:     o_cmd.rd_first   = 1'b1;
            S_CARRY:    o_cmd.take_carry = 1'b1;
            S_CMP:      o_cmd.step       = 1'b1;
            S_WLAST:    o_cmd.wlast      = 1'b1;
            S_BS_ISSUE: o_cmd.bs_issue   = !i_sts.bs_empty;
            S_BS_CMP:   o_cmd.bs_cmp     = 1'b1;
            S_DONE:     o_cmd.publish    = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/skts_dp.sv =====
// Datapath of the sorted key table search block: record memory, sort carry
// register, search bounds, result and output registers. Depends on skts_pkg.
module skts_dp #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skts_pkg::t_in_item   i_item,
    input  logic                 i_out_ready,
    input  skts_pkg::t_cmd       i_cmd,
    output skts_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output skts_pkg::t_out_item  o_out_item
);
    import skts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec                    r_mem [DEPTH];
    t_rec                    r_rd;
    t_rec                    r_carry;
    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_last;
    logic [AW-1:0]           r_j;
    logic [CW-1:0]           r_left;
    logic [CW-1:0]           r_rexcl;
    logic [AW-1:0]           r_mid;
    logic signed [KEY_W-1:0] r_key;
    t_out_item               r_res;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_data;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;
    logic          full;
    logic          swap;
    logic          key_eq;
    logic          key_lt;

    assign full     = (r_count == CW'(DEPTH));
    assign swap     = $signed(r_carry.key) > $signed(r_rd.key);
    assign key_eq   = $signed(r_rd.key) == r_key;
    assign key_lt   = $signed(r_rd.key) < r_key;
    assign mid_sum  = {1'b0, r_left} + {1'b0, r_rexcl} - (CW + 1)'(1);
    assign mid_calc = AW'(mid_sum >> 1);

    always_comb begin
        rd_addr = '0;
        if (i_cmd.take_carry) begin
            rd_addr = AW'(1);
        end else if (i_cmd.step) begin
            rd_addr = r_j + AW'(2);
        end else if (i_cmd.bs_issue) begin
            rd_addr = mid_calc;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_carry;
        if (i_cmd.accept && (i_item.func == FN_INSERT) && !full) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_count);
            wr_data = '{key: i_item.key, name_tag: i_item.name_tag, grade: i_item.grade};
        end else if (i_cmd.step) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_data = swap ? r_rd : r_carry;
        end else if (i_cmd.wlast) begin
            wr_en   = 1'b1;
            wr_addr = r_last;
            wr_data = r_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && (i_item.func == FN_INSERT) && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key        <= i_item.key;
            r_last       <= AW'(r_count - CW'(1));
            r_left       <= '0;
            r_rexcl      <= r_count;
            if (i_item.func == FN_INSERT) begin
                r_res <= '{status: full ? ST_FULL : ST_INSERTED, position: '0,
                           found_name: '0, found_grade: '0, entries: '0};
            end else begin
                r_res <= '{status: ST_MISSING, position: '0,
                           found_name: '0, found_grade: '0, entries: '0};
            end
        end
        if (i_cmd.rd_first) begin
            r_j <= '0;
        end
        if (i_cmd.take_carry) begin
            r_carry <= r_rd;
        end
        if (i_cmd.step) begin
            r_j <= r_j + AW'(1);
            if (!swap) begin
                r_carry <= r_rd;
            end
        end
        if (i_cmd.wlast) begin
            r_last <= r_last - AW'(1);
        end
        if (i_cmd.bs_issue) begin
            r_mid <= mid_calc;
        end
        if (i_cmd.bs_cmp) begin
            if (key_eq) begin
                r_res.status      <= ST_FOUND;
                r_res.position    <= POS_W'(r_mid);
                r_res.found_name  <= r_rd.name_tag;
                r_res.found_grade <= r_rd.grade;
            end else if (key_lt) begin
                r_left <= CW'(r_mid) + CW'(1);
            end else begin
                r_rexcl <= CW'(r_mid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= '{status: r_res.status, position: r_res.position,
                       found_name: r_res.found_name, found_grade: r_res.found_grade,
                       entries: ENT_W'(r_count)};
        end
    end

    assign o_sts.is_search = (i_item.func == FN_SEARCH);
    assign o_sts.below_two = (r_count < CW'(2));
    assign o_sts.pass_end  = ((r_j + AW'(1)) == r_last);
    assign o_sts.last_one  = (r_last == AW'(1));
    assign o_sts.bs_empty  = !(r_left < r_rexcl);
    assign o_sts.bs_hit    = key_eq;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/sorted_key_table_search.sv =====
// Top level of the sorted key table search block.
// Joins skts_ctrl and skts_dp to the skts_in_if and skts_out_if channels.
//
// The block holds up to DEPTH records of a signed key, a name tag and a Q8.8
// grade in a single-port-write, single-port-read memory. An insert appends a
// record, or reports full. A search with n records first bubble-sorts the
// table in place, one compare and one memory write per cycle with the larger
// record carried in a register; the sort is skipped when n is below two. The
// binary search then reads the memory and compares the registered record for
// each probe, at most floor(log2 n) + 1 probes. One item is in work at a time;
// the result sits in an output register while the next item is taken.
module sorted_key_table_search #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    skts_in_if.sink           i_in,
    skts_out_if.source        o_out
);
    import skts_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    skts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    skts_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_key_table_search: inserts, full-table refusals and searches.
// A scoreboard class predicts each result from its own sorted copy of the table.
// Depends on skts_pkg, skts_in_if, skts_out_if and the block itself.
`timescale 1ns / 100ps

module testbench;
    import skts_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int QUIET_FROM   = 1200;
    localparam int DRAIN_AT     = 600;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 20;

    class table_scoreboard;
        t_rec      recs[DEPTH];
        int        held;
        t_out_item pending[$];
        int        errors;
        int        checked;

        function new();
            held    = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // Stable ascending bubble sort: only a strictly greater key moves up.
        function void sort_records();
            t_rec tmp;
            for (int p = 0; p + 1 < held; p++) begin
                for (int j = 0; j + 1 < held - p; j++) begin
                    if (recs[j].key > recs[j+1].key) begin
                        tmp       = recs[j];
                        recs[j]   = recs[j+1];
                        recs[j+1] = tmp;
                    end
                end
            end
        endfunction

        function t_out_item predict(t_in_item it);
            t_out_item r;
            int        lo;
            int        hi;
            int        mid;
            r = '0;
            if (it.func == FN_INSERT) begin
                if (held < DEPTH) begin
                    recs[held].key      = it.key;
                    recs[held].name_tag = it.name_tag;
                    recs[held].grade    = it.grade;
                    held++;
                    r.status = ST_INSERTED;
                end else begin
                    r.status = ST_FULL;
                end
            end else begin
                r.status = ST_MISSING;
                sort_records();
                lo = 0;
                hi = held - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (recs[mid].key == it.key) begin
                        r.status      = ST_FOUND;
                        r.position    = POS_W'(mid);
                        r.found_name  = recs[mid].name_tag;
                        r.found_grade = recs[mid].grade;
                        break;
                    end else if (recs[mid].key < it.key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            r.entries = ENT_W'(held);
            return r;
        endfunction

        function void note_item(t_in_item it);
            pending.push_back(predict(it));
        endfunction

        function logic signed [KEY_W-1:0] pick_key();
            if (held == 0) begin
                return $urandom;
            end
            return recs[$urandom_range(0, held - 1)].key;
        endfunction

        task report_mismatch(input string msg);
            if (errors < 50) begin
                $display("[%0t] mismatch on result %0d: %s", $realtime, checked, msg);
            end
            errors++;
        endtask

        task compare_field(input string field, input logic [31:0] got, input logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
            end
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report_mismatch("result transfer with no result expected");
            end else begin
                want = pending.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("position", 32'(got.position), 32'(want.position));
                compare_field("found_name", got.found_name, want.found_name);
                compare_field("found_grade", 32'(got.found_grade), 32'(want.found_grade));
                compare_field("entries", 32'(got.entries), 32'(want.entries));
            end
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic bursty;
    int   idle_cycles;

    table_scoreboard sb;

    skts_in_if  in_if();
    skts_out_if out_if();

    sorted_key_table_search #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Result side: random stall bursts while bursty is set, always ready otherwise.
    initial begin
        int n;
        out_if.ready = 1'b0;
        forever begin
            if (bursty && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 15);
                repeat (n) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b0;
                end
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sorted_key_table_search regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item make_item(t_func f, logic signed [KEY_W-1:0] k,
                                           logic [NAME_W-1:0] nm, logic [GRADE_W-1:0] g);
        t_in_item it;
        it.func     = f;
        it.key      = k;
        it.name_tag = nm;
        it.grade    = g;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (bursty && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
        end
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        sb.note_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [KEY_W-1:0] extreme_key();
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return 32'shffff_ffff;
        endcase
    endfunction

    function automatic t_in_item random_item();
        logic signed [KEY_W-1:0] k;
        int                      pick;
        bit                      do_insert;
        if (sb.held < DEPTH) begin
            do_insert = ($urandom_range(0, 19) == 0);
        end else begin
            do_insert = ($urandom_range(0, 9) == 0);
        end
        pick = $urandom_range(0, 99);
        if (do_insert) begin
            if (pick < 30) begin
                k = sb.pick_key();
            end else if (pick < 40) begin
                k = extreme_key();
            end else begin
                k = $urandom;
            end
            return make_item(FN_INSERT, k, $urandom, GRADE_W'($urandom_range(0, 65535)));
        end
        if (pick < 60) begin
            k = sb.pick_key();
        end else if (pick < 70) begin
            k = sb.pick_key() + ($urandom_range(0, 1) ? 1 : -1);
        end else if (pick < 75) begin
            k = extreme_key();
        end else begin
            k = $urandom;
        end
        return make_item(FN_SEARCH, k, $urandom, GRADE_W'($urandom_range(0, 65535)));
    endfunction

    initial begin
        t_in_item plan[$];
        sb          = new();
        bursty      = 1'b1;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, single record, then extremes, duplicates and misses.
        plan.push_back(make_item(FN_SEARCH, 32'sh0000_0000, 32'h0, 16'h0));
        plan.push_back(make_item(FN_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 16'hffff));
        plan.push_back(make_item(FN_SEARCH, 32'sh7fff_ffff, 32'hffff_ffff, 16'hffff));
        plan.push_back(make_item(FN_SEARCH, 32'sh0000_0000, 32'h0, 16'h0));
        plan.push_back(make_item(FN_INSERT, 32'sh8000_0000, 32'h0000_0000, 16'h0000));
        plan.push_back(make_item(FN_INSERT, 32'sh0000_0000, 32'h0000_0001, 16'h0100));
        plan.push_back(make_item(FN_INSERT, 32'sh0000_0000, 32'h0000_0002, 16'h0080));
        plan.push_back(make_item(FN_INSERT, 32'shffff_ffff, 32'ha5a5_a5a5, 16'h5a5a));
        plan.push_back(make_item(FN_SEARCH, 32'sh8000_0000, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'sh7fff_ffff, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'sh0000_0000, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'shffff_ffff, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'sh0000_0005, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'sh8000_0001, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'sh7fff_fffe, 32'h0, 16'h0));
        plan.push_back(make_item(FN_INSERT, 32'sh0000_0005, 32'h5a5a_5a5a, 16'ha5a5));
        plan.push_back(make_item(FN_SEARCH, 32'sh0000_0005, 32'h0, 16'h0));
        plan.push_back(make_item(FN_SEARCH, 32'shffff_ffff, 32'h0, 16'h0));
        foreach (plan[i]) begin
            send_item(plan[i]);
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == DRAIN_AT) begin
                wait_drained();
            end
            if (i == QUIET_FROM) begin
                bursty = 1'b0;
            end
            send_item(random_item());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("sorted_key_table_search regression: pass");
        end else begin
            $display("sorted_key_table_search regression: fail");
        end
        $finish;
    end

endmodule
